/* design/cbmf_pkg.sv */
// Shared types and constants of the CAN byte mask match filter.
`default_nettype none
package cbmf_pkg;

   localparam int RULES_DEFAULT = 16;
   localparam int RULE_INDEX_W  = 6;

   localparam logic [1:0] MODE_ADD   = 2'd0;
   localparam logic [1:0] MODE_FRAME = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [28:0] can_id;
      logic [3:0]  length;
      logic [63:0] payload;
      logic [2:0]  rule_byte;
      logic [7:0]  rule_mask;
      logic [7:0]  rule_cond;
   } req_type;

   typedef struct packed {
      logic                    status;
      logic                    match;
      logic [RULE_INDEX_W-1:0] rule_index;
   } rsp_type;

   typedef struct packed {
      logic [28:0] can_id;
      logic [2:0]  byte_sel;
      logic [7:0]  mask;
      logic [7:0]  cond;
   } rule_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN
   } state_type;

endpackage
`default_nettype wire

/* design/cbmf_rule_mem.sv */
// Rule table: one write port, one registered read port.
`default_nettype none
module cbmf_rule_mem #(
   parameter int RULES = cbmf_pkg::RULES_DEFAULT
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [(RULES > 1 ? $clog2(RULES) : 1)-1:0] wr_addr,
   input  wire cbmf_pkg::rule_type                       wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [(RULES > 1 ? $clog2(RULES) : 1)-1:0] rd_addr,
   output cbmf_pkg::rule_type                            rd_data
);
   import cbmf_pkg::*;

   rule_type mem_ff [RULES];
   rule_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* design/cbmf_scan_ctrl.sv */
// Command sequencer: rule append, table clear and in-order rule scan.
`default_nettype none
module cbmf_scan_ctrl #(
   parameter int RULES = cbmf_pkg::RULES_DEFAULT
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     start,
   input  wire cbmf_pkg::req_type                        req_data,
   output logic                                          busy,
   output logic                                          rsp_valid,
   output cbmf_pkg::rsp_type                             rsp_data,
   output logic                                          wr_en,
   output logic [(RULES > 1 ? $clog2(RULES) : 1)-1:0]    wr_addr,
   output cbmf_pkg::rule_type                            wr_data,
   output logic                                          rd_en,
   output logic [(RULES > 1 ? $clog2(RULES) : 1)-1:0]    rd_addr,
   input  wire cbmf_pkg::rule_type                       rd_data
);
   import cbmf_pkg::*;

   localparam int IDX_W = (RULES > 1) ? $clog2(RULES) : 1;
   localparam int CNT_W = $clog2(RULES + 1);

   state_type        state_ff, state_in;
   req_type          req_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] scan_idx_ff, scan_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             accept;
   logic             table_full;
   logic             table_empty;
   logic [7:0]       sel_byte;
   logic             rule_hit;
   logic [CNT_W-1:0] scan_cnt;
   logic             scan_last;

   assign accept      = start && (state_ff == ST_IDLE);
   assign table_full  = (count_ff == CNT_W'(RULES));
   assign table_empty = (count_ff == '0);

   // Rule test against the latched frame, on the entry read last cycle.
   assign sel_byte  = req_ff.payload[{rd_data.byte_sel, 3'b000} +: 8];
   assign rule_hit  = (rd_data.can_id == req_ff.can_id)
                   && ({1'b0, rd_data.byte_sel} < req_ff.length)
                   && ((sel_byte & rd_data.mask) == rd_data.cond);
   assign scan_cnt  = CNT_W'(scan_idx_ff) + CNT_W'(1);
   assign scan_last = (scan_cnt == count_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (req_ff.mode == MODE_FRAME && !table_empty) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (rule_hit || scan_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      wr_en        = 1'b0;
      wr_addr      = count_ff[IDX_W-1:0];
      wr_data      = '{can_id:   req_ff.can_id,
                       byte_sel: req_ff.rule_byte,
                       mask:     req_ff.rule_mask,
                       cond:     req_ff.rule_cond};
      rd_en        = 1'b0;
      rd_addr      = '0;
      count_in     = count_ff;
      scan_idx_in  = scan_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      case (state_ff)
         ST_DISPATCH: begin
            case (req_ff.mode)
               MODE_ADD: begin
                  rsp_valid_in = 1'b1;
                  if (table_full) begin
                     rsp_in.status = 1'b1;
                  end else begin
                     wr_en             = 1'b1;
                     rsp_in.rule_index = RULE_INDEX_W'(count_ff);
                     count_in          = count_ff + CNT_W'(1);
                  end
               end
               MODE_FRAME: begin
                  // prefetch rule 0; an empty table misses at once
                  rd_en        = 1'b1;
                  scan_idx_in  = '0;
                  rsp_valid_in = table_empty;
               end
               MODE_CLEAR: begin
                  count_in     = '0;
                  rsp_valid_in = 1'b1;
               end
               default: rsp_valid_in = 1'b1;
            endcase
         end
         ST_SCAN: begin
            if (rule_hit) begin
               rsp_valid_in      = 1'b1;
               rsp_in.match      = 1'b1;
               rsp_in.rule_index = RULE_INDEX_W'(scan_idx_ff);
            end else if (scan_last) begin
               rsp_valid_in = 1'b1;
            end else begin
               // advance: fetch the next rule while this one is tested
               rd_en       = 1'b1;
               rd_addr     = scan_idx_ff + IDX_W'(1);
               scan_idx_in = rd_addr;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      scan_idx_ff <= scan_idx_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

/* design/can_byte_mask_match_filter_unit.sv */
// Top level of the CAN byte mask match filter.
// A command is taken when start is high and busy is low. Adding a rule, clearing the table
// or an unused mode strobes its result from a register set in the dispatch state. A frame
// scans the stored rules in order, one rule per cycle through the single read port of the
// rule memory, up to RULES of them, and strobes once a rule hits or the last one misses;
// an empty table strobes from the dispatch state. rsp_valid is high for one cycle and
// cannot be held off; busy is already low in that cycle, so the next command may start.
`default_nettype none
module can_byte_mask_match_filter_unit #(
   parameter int RULES = cbmf_pkg::RULES_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire cbmf_pkg::req_type req_data,
   output logic                   busy,
   output logic                   rsp_valid,
   output cbmf_pkg::rsp_type      rsp_data
);
   import cbmf_pkg::*;

   localparam int IDX_W = (RULES > 1) ? $clog2(RULES) : 1;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   rule_type         wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   rule_type         rd_data;

   cbmf_scan_ctrl #(.RULES(RULES)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   cbmf_rule_mem #(.RULES(RULES)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule
`default_nettype wire

/* design/cbmf_checker.sv */
// Port-level checks of the filter unit, bound to the top level.
`default_nettype none
module cbmf_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              rsp_valid,
   input wire cbmf_pkg::rsp_type rsp_data
);
   import cbmf_pkg::*;

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after a command beat");

   a_rsp_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobes on adjacent cycles");

   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status) |-> (!rsp_data.match && rsp_data.rule_index == '0))
      else $error("table full result carries a match or index");

   a_beat_while_free: assert property (@(posedge clock) disable iff (reset)
      (busy && $past(!busy) && !$past(reset)) |-> $past(start))
      else $error("busy raised without a command beat");

endmodule

bind can_byte_mask_match_filter_unit cbmf_checker u_cbmf_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
`default_nettype wire
